>>> hdl/bfdh_pkg.sv
package bfdh_pkg;

   // fixed field and hash widths
   localparam int HASH_W = 64;
   localparam int BYTE_W = 8;
   localparam int CFG_W  = 21;

   // bit store row geometry
   localparam int WORD_W    = 64;
   localparam int BIT_IDX_W = 6;

   // defaults for the top level parameters
   localparam int DEF_MAX_BITS   = 1048576;
   localparam int DEF_NUM_HASHES = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // hash seeds and register reset
   localparam logic [HASH_W-1:0] FIRST_INIT   = 64'd5381;
   localparam logic [HASH_W-1:0] SECOND_INIT  = 64'd0;
   localparam logic [CFG_W-1:0]  FILTER_RESET = 21'd819200;

   // one finished key handed from front to back
   typedef struct packed {
      logic [HASH_W-1:0] first_hash;
      logic [HASH_W-1:0] second_hash;
      logic              check;
   } queue_entry_type;

   // status seen by the front
   typedef struct packed {
      logic clearing;
      logic q_full;
   } front_ctrl_type;

endpackage

>>> hdl/bfdh_front.sv
module bfdh_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_last_byte,
   input  logic                          req_mode,
   input  bfdh_pkg::front_ctrl_type      ctrl,
   output logic                          push,
   output bfdh_pkg::queue_entry_type     push_entry
);
   import bfdh_pkg::*;

   logic [HASH_W-1:0] first_ff, first_in;
   logic [HASH_W-1:0] second_ff, second_in;
   logic [HASH_W-1:0] byte_ext;
   logic              accept;

   // hold items while the store is cleared or the queue is full
   assign req_stall = ctrl.clearing | ctrl.q_full;
   assign accept    = req_valid & ~req_stall;
   assign byte_ext  = {{(HASH_W-BYTE_W){1'b0}}, req_key_byte};

   // djb2 and sdbm folding of one byte
   always_comb begin
      first_in  = (first_ff << 5) + first_ff + byte_ext;
      second_in = byte_ext + (second_ff << 6) + (second_ff << 16) - second_ff;
   end

   // a finished key goes to the queue
   assign push                   = accept & req_last_byte;
   assign push_entry.first_hash  = first_in;
   assign push_entry.second_hash = second_in;
   assign push_entry.check       = req_mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= FIRST_INIT;
         second_ff <= SECOND_INIT;
      end else if (accept) begin
         if (req_last_byte) begin
            first_ff  <= FIRST_INIT;
            second_ff <= SECOND_INIT;
         end else begin
            first_ff  <= first_in;
            second_ff <= second_in;
         end
      end
   end

endmodule

>>> hdl/bfdh_queue.sv
module bfdh_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bfdh_pkg::queue_entry_type     push_entry,
   input  logic                          pop,
   output logic                          q_valid,
   output logic                          q_full,
   output bfdh_pkg::queue_entry_type     q_entry
);
   import bfdh_pkg::*;

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                do_push;
   logic                do_pop;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_entry = slot_ff[rd_ptr_ff];
   assign do_push = push & ~q_full;
   assign do_pop  = pop & q_valid;

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count, depth is a power of two
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push & ~do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop & ~do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> hdl/bfdh_back.sv
module bfdh_back #(
   parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
   parameter int NUM_HASHES = bfdh_pkg::DEF_NUM_HASHES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [20:0]                   csr_wr_data,
   input  logic                          q_valid,
   input  bfdh_pkg::queue_entry_type     q_entry,
   output logic                          pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_maybe_present
);
   import bfdh_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_BITS);
   localparam int DIG_W   = (ADDR_W > BIT_IDX_W) ? ADDR_W : BIT_IDX_W + 1;
   localparam int ROWS    = (MAX_BITS + WORD_W - 1) / WORD_W;
   localparam int ROW_W   = DIG_W - BIT_IDX_W;
   localparam int SIZE_W  = $clog2(MAX_BITS + 1);
   localparam int CMP_W   = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
   localparam int HIDX_W  = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
   localparam int DCNT_W  = $clog2(HASH_W);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_READ,
      S_APPLY,
      S_OUT
   } state_type;

   state_type           state_ff;
   logic [CFG_W-1:0]    filter_bits_ff;
   logic [ROW_W-1:0]    clear_row_ff;
   logic [HASH_W-1:0]   sum_ff;
   logic [HASH_W-1:0]   step_ff;
   logic [HASH_W-1:0]   dvd_ff;
   logic [CMP_W-1:0]    rem_ff;
   logic [CMP_W-1:0]    size_ff;
   logic [DCNT_W-1:0]   div_cnt_ff;
   logic [HIDX_W-1:0]   hidx_ff;
   logic                check_ff;
   logic                all_ff;
   logic                rsp_valid_ff;
   logic                rsp_data_ff;

   logic [WORD_W-1:0]   mem [ROWS];
   logic [WORD_W-1:0]   rdata_ff;

   logic [CMP_W-1:0]    cfg_ext;
   logic [CMP_W-1:0]    size_in;
   logic [CMP_W:0]      rem_sh;
   logic [CMP_W:0]      rem_sub;
   logic [CMP_W-1:0]    rem_in;
   logic [HASH_W-1:0]   sum_in;
   logic [DIG_W-1:0]    digest;
   logic [ROW_W-1:0]    rd_row;
   logic                hit_bit;
   logic                mem_we;
   logic [ROW_W-1:0]    wr_row;
   logic [WORD_W-1:0]   wr_data;
   logic                out_free;

   // filter size register
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= FILTER_RESET;
      end else if (csr_wr_en) begin
         filter_bits_ff <= csr_wr_data;
      end
   end

   // modulus clamped to one .. max bits
   always_comb begin
      cfg_ext = {{(CMP_W-CFG_W){1'b0}}, filter_bits_ff};
      if (cfg_ext == '0) begin
         size_in = CMP_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_BITS)) begin
         size_in = CMP_W'(MAX_BITS);
      end else begin
         size_in = cfg_ext;
      end
   end

   // one restoring remainder step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[HASH_W-1]};
      rem_sub = rem_sh - {1'b0, size_ff};
      rem_in  = (rem_sh >= {1'b0, size_ff}) ? rem_sub[CMP_W-1:0] : rem_sh[CMP_W-1:0];
   end

   // next digest input and current bit address
   assign sum_in  = sum_ff + step_ff;
   assign digest  = rem_ff[DIG_W-1:0];
   assign rd_row  = digest[DIG_W-1:BIT_IDX_W];
   assign hit_bit = rdata_ff[digest[BIT_IDX_W-1:0]];

   // store write port: clearing pass or read-modify-write on add
   always_comb begin
      mem_we  = 1'b0;
      wr_row  = rd_row;
      wr_data = rdata_ff | (WORD_W'(1) << digest[BIT_IDX_W-1:0]);
      if (state_ff == S_CLEAR) begin
         mem_we  = 1'b1;
         wr_row  = clear_row_ff;
         wr_data = '0;
      end else if (state_ff == S_APPLY && !check_ff) begin
         mem_we = 1'b1;
      end
   end

   // bit store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_row] <= wr_data;
      end
      rdata_ff <= mem[rd_row];
   end

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign pop       = (state_ff == S_IDLE) & q_valid;
   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_maybe_present = rsp_data_ff;

   // back end sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: load a new result or drop an accepted one
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clear_row_ff <= clear_row_ff + 1'b1;
               if (clear_row_ff == ROW_W'(ROWS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  sum_ff     <= q_entry.first_hash;
                  step_ff    <= q_entry.second_hash;
                  dvd_ff     <= q_entry.first_hash;
                  check_ff   <= q_entry.check;
                  size_ff    <= size_in;
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  hidx_ff    <= '0;
                  all_ff     <= 1'b1;
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff     <= rem_in;
               dvd_ff     <= dvd_ff << 1;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DCNT_W'(HASH_W - 1)) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (check_ff) begin
                  all_ff <= all_ff & hit_bit;
               end
               if (hidx_ff == HIDX_W'(NUM_HASHES - 1)) begin
                  state_ff <= check_ff ? S_OUT : S_IDLE;
               end else begin
                  hidx_ff    <= hidx_ff + 1'b1;
                  sum_ff     <= sum_in;
                  dvd_ff     <= sum_in;
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= S_DIV;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_data_ff  <= all_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> hdl/bloom_filter_double_hash_top.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_key_byte, req_last_byte, req_mode
// rsp       out        rsp_valid/rsp_stall  rsp_maybe_present
// csr       in         csr_wr_en            csr_wr_data (filter size)
//
// a key byte is taken when req_valid is high and req_stall is low; the hashes are folded at the input
// a finished key leaves the queue, then for each digest the back end runs 64 remainder
// steps, one store read and one update
// a check result is issued from a separate output state; a stalled rsp holds the back end
// after reset the bit store is cleared one 64-bit row a cycle, with req stalled;
// req also stalls while the queue is full
module bloom_filter_double_hash_top #(
   parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
   parameter int NUM_HASHES = bfdh_pkg::DEF_NUM_HASHES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   input  logic        req_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_maybe_present,
   input  logic        csr_wr_en,
   input  logic [20:0] csr_wr_data
);
   import bfdh_pkg::*;

   front_ctrl_type  ctrl;
   queue_entry_type push_entry;
   queue_entry_type q_entry;
   logic            push;
   logic            pop;
   logic            q_valid;
   logic            q_full;
   logic            clearing;

   assign ctrl.clearing = clearing;
   assign ctrl.q_full   = q_full;

   // byte hashing and input handshake
   bfdh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_key_byte  (req_key_byte),
      .req_last_byte (req_last_byte),
      .req_mode      (req_mode),
      .ctrl          (ctrl),
      .push          (push),
      .push_entry    (push_entry)
   );

   // finished keys waiting for the back end
   bfdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_entry    (q_entry)
   );

   // digests, bit store and result
   bfdh_back #(
      .MAX_BITS   (MAX_BITS),
      .NUM_HASHES (NUM_HASHES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_maybe_present (rsp_maybe_present)
   );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bfdh_pkg::*;

   // key mode codes
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   localparam int STORE_ROWS   = DEF_MAX_BITS / WORD_W;
   localparam int DRAIN_CYCLES = 800;
   localparam int HOLDOFF_LEN  = 3000;
   localparam int KEY_MAX      = 20;

   typedef struct packed {
      logic [BYTE_W-1:0] key_byte;
      logic              last_byte;
      logic              mode;
   } filter_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_key_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              req_mode = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_maybe_present;
   logic              csr_wr_en = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = FILTER_RESET;

   // stimulus and prediction state
   filter_item_type   key_items [$];
   filter_item_type   next_item;
   logic              presence_expected [$];
   bit [HASH_W-1:0]   djb2_acc = FIRST_INIT;
   bit [HASH_W-1:0]   sdbm_acc = SECOND_INIT;
   bit [CFG_W-1:0]    filter_size_copy = FILTER_RESET;
   bit [WORD_W-1:0]   store_rows [0:STORE_ROWS-1];
   bit [8*KEY_MAX-1:0] pool_bytes [$];
   int                pool_len [$];
   int                items_queued = 0;
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   logic              holdoff_start = 1'b0;
   int                holdoff_count = 0;

   bloom_filter_double_hash_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_byte      (req_key_byte),
      .req_last_byte     (req_last_byte),
      .req_mode          (req_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_maybe_present (rsp_maybe_present),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // fold one accepted item into the hashes, update or probe the filter on the last byte
   task automatic predict_filter_item(input logic [7:0] kb, input logic last, input logic md);
      bit [HASH_W-1:0] size;
      bit [HASH_W-1:0] digest;
      bit [HASH_W-1:0] k;
      bit              all_set;
      djb2_acc = (djb2_acc << 5) + djb2_acc + kb;
      sdbm_acc = kb + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
      if (last) begin
         size = HASH_W'(filter_size_copy);
         if (size == 0) size = HASH_W'(1);
         if (size > DEF_MAX_BITS) size = HASH_W'(DEF_MAX_BITS);
         all_set = 1'b1;
         for (k = 0; k < DEF_NUM_HASHES; k++) begin
            digest = djb2_acc + k * sdbm_acc;
            digest = digest % size;
            if (md == MODE_CHECK) begin
               if (!store_rows[digest >> BIT_IDX_W][digest[BIT_IDX_W-1:0]]) all_set = 1'b0;
            end else begin
               store_rows[digest >> BIT_IDX_W][digest[BIT_IDX_W-1:0]] = 1'b1;
            end
         end
         if (md == MODE_CHECK) presence_expected.push_back(all_set);
         djb2_acc = FIRST_INIT;
         sdbm_acc = SECOND_INIT;
      end
   endtask

   // driver: predict on acceptance, then offer the next pending item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_filter_item(req_key_byte, req_last_byte, req_mode);
         if (!req_valid || !req_stall) begin
            if (key_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = key_items.pop_front();
               req_valid     <= 1'b1;
               req_key_byte  <= next_item.key_byte;
               req_last_byte <= next_item.last_byte;
               req_mode      <= next_item.mode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (holdoff_start) begin
         holdoff_count <= HOLDOFF_LEN;
      end else if (holdoff_count != 0) begin
         holdoff_count <= holdoff_count - 1;
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_count != 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (presence_expected.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: maybe_present=%b", rsp_maybe_present);
            mismatch_count++;
         end else if (rsp_maybe_present !== presence_expected[0]) begin
            if (mismatch_count < 10)
               $display("maybe_present mismatch: expected %b, got %b",
                        presence_expected[0], rsp_maybe_present);
            mismatch_count++;
            void'(presence_expected.pop_front());
         end else begin
            void'(presence_expected.pop_front());
         end
      end
   end

   // push one key, byte 0 in the low bits; mode on inner bytes is ignored by the block
   task automatic queue_key(input bit [8*KEY_MAX-1:0] kbytes, input int klen, input logic md);
      filter_item_type it;
      int j;
      for (j = 0; j < klen; j++) begin
         it.key_byte  = kbytes[8*j +: 8];
         it.last_byte = (j == klen - 1);
         it.mode      = it.last_byte ? md : logic'($urandom_range(1));
         key_items.push_back(it);
         items_queued++;
      end
   endtask

   // mostly short keys, now and then a long one, the odd zero byte
   task automatic make_key(output bit [8*KEY_MAX-1:0] kbytes, output int klen);
      int j;
      kbytes = '0;
      klen = ($urandom_range(9) == 0) ? $urandom_range(KEY_MAX, 9) : $urandom_range(8, 1);
      for (j = 0; j < klen; j++)
         kbytes[8*j +: 8] = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
   endtask

   // mix of adds, re-checks of added keys, fresh checks and truncated keys
   task automatic random_keys(input int n_items);
      bit [8*KEY_MAX-1:0] kbytes;
      int klen;
      int pick;
      int r;
      int stop_at;
      stop_at = items_queued + n_items;
      while (items_queued < stop_at) begin
         r = $urandom_range(99);
         if (r < 40 || pool_len.size() == 0) begin
            make_key(kbytes, klen);
            queue_key(kbytes, klen, MODE_ADD);
            pool_bytes.push_back(kbytes);
            pool_len.push_back(klen);
         end else if (r < 75) begin
            pick = $urandom_range(pool_len.size() - 1);
            queue_key(pool_bytes[pick], pool_len[pick], MODE_CHECK);
         end else if (r < 90) begin
            make_key(kbytes, klen);
            queue_key(kbytes, klen, MODE_CHECK);
         end else begin
            pick = $urandom_range(pool_len.size() - 1);
            klen = $urandom_range(pool_len[pick], 1);
            queue_key(pool_bytes[pick], klen, logic'($urandom_range(1)));
         end
      end
   endtask

   // wait for the block to go quiet, allowing for queued add keys with no result
   task automatic drain_block();
      while (key_items.size() != 0 || req_valid || presence_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_filter_bits(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      filter_size_copy = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // main sequence
   initial begin
      int phase_sizes [9];
      int p;
      phase_sizes = '{64, 0, 2097151, 1, 0, 1048576, 819200, 0, 1048575};
      phase_sizes[4] = $urandom_range(5000, 2);
      phase_sizes[7] = $urandom_range(21'h1FFFFF, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset modulus, single bytes, a zero byte inside a key
      set_idling(0, 0);
      queue_key(160'hFF, 1, MODE_ADD);
      queue_key(160'hFF, 1, MODE_CHECK);
      queue_key(160'h01, 1, MODE_CHECK);
      queue_key(160'h4100, 2, MODE_ADD);
      queue_key(160'h4100, 2, MODE_CHECK);
      queue_key(160'h41, 1, MODE_CHECK);
      drain_block();

      // directed: modulus zero maps every digest to bit zero
      set_filter_bits(21'd0);
      set_idling(0, 0);
      queue_key(160'h80, 1, MODE_CHECK);
      queue_key(160'h7F, 1, MODE_ADD);
      queue_key(160'h02, 1, MODE_CHECK);
      drain_block();

      // directed: modulus above the store size is clamped
      set_filter_bits(21'h1FFFFF);
      set_idling(0, 0);
      queue_key(160'hFF, 1, MODE_CHECK);
      queue_key(160'hFF55AA, 3, MODE_ADD);
      queue_key(160'hFF55AA, 3, MODE_CHECK);
      queue_key(160'h55AA, 2, MODE_CHECK);
      drain_block();

      // random phases over a range of moduli and idling patterns
      for (p = 0; p < 9; p++) begin
         set_filter_bits(CFG_W'(phase_sizes[p]));
         case (p % 4)
            0: set_idling(0, 0);
            1: set_idling(62, 0);
            2: set_idling(0, 62);
            default: set_idling(15, 15);
         endcase
         if (p == 0) begin
            @(posedge clock);
            holdoff_start <= 1'b1;
            @(posedge clock);
            holdoff_start <= 1'b0;
            @(negedge clock);
         end
         random_keys(55);
         drain_block();
      end

      if (mismatch_count == 0 && presence_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
hdl/bfdh_pkg.sv
hdl/bfdh_front.sv
hdl/bfdh_queue.sv
hdl/bfdh_back.sv
hdl/bloom_filter_double_hash_top.sv
bench/testbench.sv
